// File: rtl/fscr_pkg.sv
`timescale 1ns / 1ps
package fscr_pkg;
  localparam int unsigned DefMaxFragments = 64;
  localparam int unsigned QOne = 32768;
  localparam int unsigned SumMax = 4194303;
  localparam int unsigned SumW = 22;

  typedef struct packed {
    logic [31:0] key;
    logic [15:0] col_r;
    logic [15:0] col_g;
    logic [15:0] col_b;
    logic [15:0] opa_r;
    logic [15:0] opa_g;
    logic [15:0] opa_b;
  } frag_t;

  typedef struct packed {
    logic        has_fragment;
    logic [31:0] depth;
    logic [15:0] color_red;
    logic [15:0] color_green;
    logic [15:0] color_blue;
    logic [15:0] opacity_red;
    logic [15:0] opacity_green;
    logic [15:0] opacity_blue;
    logic        end_of_sample;
    logic        end_of_pixel;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_red;
    logic [15:0] pixel_green;
    logic [15:0] pixel_blue;
    logic [15:0] pixel_alpha;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input item
    logic scan;       // compare one store entry against the key
    logic shift;      // move entry idx-1 to idx
    logic place;      // write new fragment at idx
    logic comp_init;  // clear accumulators
    logic comp_rd;    // read entry for composite
    logic comp_mul;   // multiply stage
    logic comp_acc;   // accumulate stage
    logic close;      // add sample to pixel sums
    logic cov;        // coverage step
    logic div_init;   // start divider
    logic div_step;   // one divider step
    logic emit;       // load output register, clear sums
  } cmd_t;

  typedef struct packed {
    logic is_le;      // entry key <= new key
  } sts_t;

  function automatic logic [15:0] sat16(input logic [16:0] v);
    sat16 = v[16] ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [SumW-1:0] sat_sum(input logic [SumW:0] v);
    sat_sum = v[SumW] ? SumW'(SumMax) : v[SumW-1:0];
  endfunction
endpackage

// File: rtl/fscr_if.sv
`timescale 1ns / 1ps
interface fscr_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/fscr_datapath.sv
`timescale 1ns / 1ps
module fscr_datapath import fscr_pkg::*; #(
  parameter int unsigned MaxFragments = DefMaxFragments,
  parameter int unsigned IdxW = $clog2(MaxFragments + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmd_t            cmd_i,
  input  logic [IdxW-1:0] idx_i,
  input  in_item_t        item_i,
  input  logic [6:0]      spp_i,
  output sts_t            sts_o,
  output in_item_t        item_o,
  output out_item_t       res_o
);
  localparam int unsigned AW = (MaxFragments > 1) ? $clog2(MaxFragments) : 1;
  localparam int unsigned NumW = SumW + 1;

  frag_t mem_q [MaxFragments];
  frag_t rd_q;
  in_item_t item_q;
  frag_t nf;
  logic [AW-1:0] a_rd, a_wr;

  logic [15:0] acc_q [3];
  logic [31:0] prod_q [3];
  logic [SumW-1:0] osum_q [3];
  logic [15:0] col_q [3];
  logic [SumW-1:0] sum_q [4];
  logic [NumW-1:0] cov_q;
  logic [NumW-1:0] num_q [4];
  logic [SumW-1:0] rem_q [4];
  logic [NumW-1:0] quo_q [4];
  logic [6:0] dv;

  assign nf = '{key: item_q.depth ^ 32'h8000_0000, col_r: item_q.color_red,
                col_g: item_q.color_green, col_b: item_q.color_blue,
                opa_r: item_q.opacity_red, opa_g: item_q.opacity_green,
                opa_b: item_q.opacity_blue};
  // scan and composite read idx-1; shift reads idx-1 and writes idx
  assign a_rd = AW'(idx_i - IdxW'(1));
  assign a_wr = AW'(idx_i);
  assign dv = (spp_i == 7'd0) ? 7'd1 : spp_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
    rd_q <= mem_q[a_rd];
    if (cmd_i.shift) mem_q[a_wr] <= rd_q;
    if (cmd_i.place) mem_q[a_wr] <= nf;
  end
  assign sts_o.is_le = rd_q.key <= nf.key;
  assign item_o = item_q;

  logic [15:0] rc [3], ro [3], om [3];
  assign rc[0] = rd_q.col_r; assign rc[1] = rd_q.col_g; assign rc[2] = rd_q.col_b;
  assign ro[0] = rd_q.opa_r; assign ro[1] = rd_q.opa_g; assign ro[2] = rd_q.opa_b;
  for (genvar k = 0; k < 3; k++) begin : g_ch
    assign om[k] = (ro[k] >= 16'(QOne)) ? 16'd0 : 16'(QOne) - ro[k];
    always_ff @(posedge clk_i) begin
      if (cmd_i.comp_init) begin
        acc_q[k] <= '0; osum_q[k] <= '0;
      end
      if (cmd_i.comp_mul) begin
        prod_q[k] <= acc_q[k] * om[k];
        col_q[k] <= rc[k];
        osum_q[k] <= osum_q[k] + SumW'(ro[k]);
      end
      if (cmd_i.comp_acc)
        acc_q[k] <= sat16(17'((33'(prod_q[k]) + 33'd16384) >> 15) + 17'(col_q[k]));
    end
  end

  // cov = floor((s+1)/3) via reciprocal ceil(2^25/3); exact for s + 1 < 2^25
  logic [23:0] cs;
  logic [47:0] cm;
  assign cs = 24'(osum_q[0]) + 24'(osum_q[1]) + 24'(osum_q[2]) + 24'd1;
  assign cm = 48'(cs) * 48'd11184811;
  always_ff @(posedge clk_i) begin
    if (cmd_i.cov) cov_q <= cm[47:25];
  end

  logic [15:0] covc;
  assign covc = (cov_q > NumW'(QOne)) ? 16'(QOne) : cov_q[15:0];
  logic [15:0] addv [4];
  assign addv[0] = acc_q[0]; assign addv[1] = acc_q[1];
  assign addv[2] = acc_q[2]; assign addv[3] = covc;
  logic [SumW:0] remsh [4];
  for (genvar k = 0; k < 4; k++) begin : g_sum
    assign remsh[k] = {rem_q[k], num_q[k][NumW-1]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sum_q[k] <= '0;
      else if (cmd_i.emit) sum_q[k] <= '0;
      else if (cmd_i.close)
        sum_q[k] <= sat_sum((SumW+1)'(sum_q[k]) + (SumW+1)'(addv[k]));
    end
    always_ff @(posedge clk_i) begin
      if (cmd_i.div_init) begin
        num_q[k] <= NumW'(sum_q[k]) + NumW'(dv >> 1);
        rem_q[k] <= '0; quo_q[k] <= '0;
      end
      if (cmd_i.div_step) begin
        num_q[k] <= num_q[k] << 1;
        if (remsh[k] >= (SumW+1)'(dv)) begin
          rem_q[k] <= SumW'(remsh[k] - (SumW+1)'(dv));
          quo_q[k] <= {quo_q[k][NumW-2:0], 1'b1};
        end else begin
          rem_q[k] <= remsh[k][SumW-1:0];
          quo_q[k] <= {quo_q[k][NumW-2:0], 1'b0};
        end
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_o.pixel_red   <= (quo_q[0] > NumW'(16'hFFFF)) ? 16'hFFFF : quo_q[0][15:0];
      res_o.pixel_green <= (quo_q[1] > NumW'(16'hFFFF)) ? 16'hFFFF : quo_q[1][15:0];
      res_o.pixel_blue  <= (quo_q[2] > NumW'(16'hFFFF)) ? 16'hFFFF : quo_q[2][15:0];
      res_o.pixel_alpha <= (quo_q[3] > NumW'(QOne)) ? 16'(QOne) : quo_q[3][15:0];
    end
  end
endmodule

// File: rtl/fscr_ctrl.sv
`timescale 1ns / 1ps
module fscr_ctrl import fscr_pkg::*; #(
  parameter int unsigned MaxFragments = DefMaxFragments,
  parameter int unsigned IdxW = $clog2(MaxFragments + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  in_item_t        item_i,
  input  sts_t            sts_i,
  output cmd_t            cmd_o,
  output logic [IdxW-1:0] idx_o
);
  localparam logic [3:0] SIdle = 4'd0, SScanRd = 4'd1, SScan = 4'd2, SShift = 4'd3,
                         SPlace = 4'd4, SClose = 4'd5, SCRd = 4'd6, SCMul = 4'd7,
                         SCAcc = 4'd8, SCov = 4'd9, SSum = 4'd10, SDivI = 4'd11,
                         SDiv = 4'd12, SEmit = 4'd13, SWait = 4'd14;
  logic [3:0] st_q, st_d;
  logic [IdxW-1:0] idx_q, idx_d, cnt_q, cnt_d;
  logic [4:0] dc_q, dc_d;
  logic ov_q, ov_d;

  assign idx_o = idx_q;
  assign in_ready_o = (st_q == SIdle);
  assign out_valid_o = ov_q;

  always_comb begin
    st_d = st_q; idx_d = idx_q; cnt_d = cnt_q; dc_d = dc_q; ov_d = ov_q;
    cmd_o = '0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (st_q)
      SIdle: if (in_valid_i) begin
        cmd_o.load = 1'b1;
        idx_d = cnt_q;
        st_d = SScanRd;
      end
      SScanRd: begin
        if (!item_i.has_fragment || cnt_q == IdxW'(MaxFragments)) st_d = SClose;
        else if (idx_q == '0) st_d = SPlace;
        else st_d = SScan;
      end
      SScan: begin
        if (sts_i.is_le) st_d = SPlace;
        else begin
          cmd_o.shift = 1'b1;
          idx_d = idx_q - IdxW'(1);
          st_d = SShift;
        end
      end
      SShift: st_d = (idx_q == '0) ? SPlace : SScan;
      SPlace: begin
        cmd_o.place = 1'b1;
        cnt_d = cnt_q + IdxW'(1);
        st_d = SClose;
      end
      SClose: begin
        if (item_i.end_of_sample || item_i.end_of_pixel) begin
          cmd_o.comp_init = 1'b1;
          idx_d = cnt_q;
          st_d = (cnt_q == '0) ? SCov : SCRd;
        end else st_d = SIdle;
      end
      SCRd: st_d = SCMul;
      SCMul: begin
        cmd_o.comp_mul = 1'b1;
        st_d = SCAcc;
      end
      SCAcc: begin
        cmd_o.comp_acc = 1'b1;
        idx_d = idx_q - IdxW'(1);
        st_d = (idx_q == IdxW'(1)) ? SCov : SCRd;
      end
      SCov: begin
        cmd_o.cov = 1'b1;
        st_d = SSum;
      end
      SSum: begin
        cmd_o.close = 1'b1;
        cnt_d = '0;
        st_d = item_i.end_of_pixel ? SDivI : SIdle;
      end
      SDivI: begin
        cmd_o.div_init = 1'b1;
        dc_d = 5'(SumW + 1);
        st_d = SDiv;
      end
      SDiv: begin
        cmd_o.div_step = 1'b1;
        dc_d = dc_q - 5'd1;
        if (dc_q == 5'd1) st_d = SWait;
      end
      SWait: if (!ov_q || out_ready_i) begin
        cmd_o.emit = 1'b1;
        ov_d = 1'b1;
        st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; idx_q <= '0; cnt_q <= '0; dc_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; idx_q <= idx_d; cnt_q <= cnt_d; dc_q <= dc_d; ov_q <= ov_d;
    end
  end

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= IdxW'(MaxFragments)) else $error("fragment count overflow");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !(cmd_o.shift || cmd_o.place)) else $error("store write while idle");
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> ov_q) else $error("result not presented");
  a_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.close |=> cnt_q == '0) else $error("count not cleared");
endmodule

// File: rtl/fragment_sort_composite_resolve.sv
`timescale 1ns / 1ps
// Fragment sort and composite resolve: one pixel from its sub-sample fragments.
// Input channel in_if (fscr_if of in_item_t): one fragment or boundary marker
// per item, accepted when valid and ready are both high.
// Output channel out_if (fscr_if of out_item_t): one filtered pixel per item
// carrying end_of_pixel; the result stays in a register until taken.
// Configuration: cfg_we_i writes samples_per_pixel from cfg_data_i (reset 1).
// Sequence: a marker item is loaded and goes straight to the sample close. A
// fragment item is inserted in sorted order: each stored fragment that it passes
// is compared and then moved one place back, and a last compare stops it when it
// lies behind a stored fragment. Closing a sample walks the store back to front,
// reading, multiplying and accumulating each fragment. A pixel end then starts
// the bit-serial box-filter division, runs it and loads the output register.
// Reset clears the count, the pixel sums and the output valid; store contents
// are left as they are. If the receiver stalls, the next pixel waits in the
// divider until the output register frees; input is held off meanwhile.
module fragment_sort_composite_resolve import fscr_pkg::*; #(
  parameter int unsigned MaxFragments = DefMaxFragments
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_we_i,
  input logic [6:0] cfg_data_i,
  fscr_if.sink      in_if,
  fscr_if.source    out_if
);
  localparam int unsigned IdxW = $clog2(MaxFragments + 1);
  cmd_t cmd;
  sts_t sts;
  logic [IdxW-1:0] idx;
  in_item_t item_q;
  logic [6:0] spp_q;

  // hold divisor register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) spp_q <= 7'd1;
    else if (cfg_we_i) spp_q <= cfg_data_i;
  end

  fscr_ctrl #(.MaxFragments(MaxFragments), .IdxW(IdxW)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .item_i(item_q), .sts_i(sts), .cmd_o(cmd), .idx_o(idx)
  );

  fscr_datapath #(.MaxFragments(MaxFragments), .IdxW(IdxW)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .idx_i(idx), .item_i(in_if.data), .spp_i(spp_q),
    .sts_o(sts), .item_o(item_q), .res_o(out_if.data)
  );
endmodule
